@@ design/b2d_pkg.sv @@
package b2d_pkg;

   // Digit width and the cap on digits emitted per item
   localparam int DIGIT_W     = 4;
   localparam int MAX_RESULTS = 39;

   // Input item: one unsigned number as two 64-bit halves
   typedef struct packed {
      logic [63:0] value_low;
      logic [63:0] value_high;
   } req_type;

   // Result item: one decimal digit, most significant first
   typedef struct packed {
      logic [DIGIT_W-1:0] digit;
      logic               last;
   } rsp_type;

endpackage

@@ design/binary128_to_decimal_digits_top.sv @@
// Channel  | Ports                        | Direction | Handshake
// ---------+------------------------------+-----------+--------------------------------
// request  | start, busy, req_item        | in        | taken at edge with start & !busy
// result   | rsp_strobe, rsp_item         | out       | one strobe per digit, no stall
//
// After the accept, the whole digit row is doubled once per input bit (one bit per
// cycle), then a scan over every digit place drops leading zeros and emits digits,
// MSB first, each a registered strobe. Synchronous active-high reset returns the
// sequencer to idle and drops the strobe. busy is high from the accept edge until the
// last digit is issued; the receiver cannot stall, so results flow at one digit per
// cycle once leading zeros are passed.
module binary128_to_decimal_digits_top
   import b2d_pkg::*;
#(
   parameter int INPUT_BITS  = 128,
   parameter int DIGIT_COUNT = 39
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   localparam int BCNT_W = $clog2(INPUT_BITS + 1);
   localparam int IDX_W  = $clog2(DIGIT_COUNT);
   localparam int LOWEST = (DIGIT_COUNT > MAX_RESULTS) ? DIGIT_COUNT - MAX_RESULTS : 0;

   localparam logic [BCNT_W-1:0] LAST_BIT = BCNT_W'(INPUT_BITS - 1);
   localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(DIGIT_COUNT - 1);
   localparam logic [IDX_W-1:0]  LOW_IDX  = IDX_W'(LOWEST);

   // Sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [BCNT_W-1:0]     bcnt_ff, bcnt_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [INPUT_BITS-1:0] bits_ff, bits_in;
   logic [DIGIT_W-1:0]    dig_ff [DIGIT_COUNT];
   logic [DIGIT_W-1:0]    dig_in [DIGIT_COUNT];
   logic [DIGIT_W-1:0]    dbl    [DIGIT_COUNT];
   logic [DIGIT_COUNT-1:0] cout;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   rsp_type               rsp_ff, rsp_in;
   logic [127:0]          value_full;

   assign value_full = {req_item.value_high, req_item.value_low};
   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   // Doubling row: carry out of a digit is set by the digit alone (d >= 5),
   // so every cell works independently of its neighbors' carry chain.
   always_comb begin
      for (int j = 0; j < DIGIT_COUNT; j++) begin
         cout[j] = (dig_ff[j] >= DIGIT_W'(5));
      end
      for (int j = 0; j < DIGIT_COUNT; j++) begin
         logic cin;
         logic [DIGIT_W-1:0] two_d;
         cin   = (j == DIGIT_COUNT - 1) ? bits_ff[INPUT_BITS-1] : cout[(j + 1) % DIGIT_COUNT];
         two_d = {dig_ff[j][DIGIT_W-2:0], cin};
         dbl[j] = cout[j] ? two_d - DIGIT_W'(10) : two_d;
      end
   end

   // Sequencer: load, convert one bit per cycle, then scan digits out
   always_comb begin
      state_in      = state_ff;
      bcnt_in       = bcnt_ff;
      idx_in        = idx_ff;
      bits_in       = bits_ff;
      dig_in        = dig_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               bits_in  = value_full[INPUT_BITS-1:0];
               bcnt_in  = '0;
               for (int j = 0; j < DIGIT_COUNT; j++) begin
                  dig_in[j] = '0;
               end
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            dig_in  = dbl;
            bits_in = {bits_ff[INPUT_BITS-2:0], 1'b0};
            bcnt_in = bcnt_ff + BCNT_W'(1);
            if (bcnt_ff == LAST_BIT) begin
               idx_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // shift the row toward the top place each cycle
            for (int j = 0; j < DIGIT_COUNT - 1; j++) begin
               dig_in[j] = dig_ff[j+1];
            end
            dig_in[DIGIT_COUNT-1] = '0;
            idx_in = idx_ff + IDX_W'(1);
            priority if (idx_ff < LOW_IDX) begin
               // places above the emit window are dropped
            end else if (!rsp_ff.last && rsp_strobe_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_in.digit  = dig_ff[0];
               rsp_in.last   = (idx_ff == LAST_IDX);
            end else if (dig_ff[0] == '0 && idx_ff != LAST_IDX) begin
               // leading zero
            end else begin
               rsp_strobe_in = 1'b1;
               rsp_in.digit  = dig_ff[0];
               rsp_in.last   = (idx_ff == LAST_IDX);
            end
            if (idx_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      bcnt_ff <= bcnt_in;
      idx_ff  <= idx_in;
      bits_ff <= bits_in;
      dig_ff  <= dig_in;
      rsp_ff  <= rsp_in;
   end

endmodule

@@ test/testbench.sv @@
module testbench
   import b2d_pkg::*;
();

   localparam int DIGIT_PLACES = MAX_RESULTS;
   localparam int RANDOM_ITEMS = 480;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int PRINT_LIMIT  = 40;

   // one number waiting to be sent, with its lead-in gap
   typedef struct {
      req_type     item;
      int unsigned gap;
      bit          drain;
   } pending_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_strobe;
   rsp_type rsp_item;

   pending_type   pending_numbers[$];
   rsp_type       expected_digits[$];
   int unsigned   idle_cycles = 0;
   int unsigned   accepted_count = 0;
   int unsigned   mismatch_count = 0;
   int unsigned   cycle_count = 0;

   binary128_to_decimal_digits_top DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      if (mismatch_count < PRINT_LIMIT)
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   // double dabble over the whole number, then queue digits MSB first
   task automatic push_decimal_digits(input logic [127:0] number);
      logic [3:0] place [DIGIT_PLACES];
      logic       carry;
      logic [4:0] doubled;
      int         top;
      rsp_type    entry;
      foreach (place[j]) place[j] = '0;
      for (int b = 127; b >= 0; b--) begin
         carry = number[b];
         // place[0] is the least significant digit
         for (int j = 0; j < DIGIT_PLACES; j++) begin
            doubled = {place[j], 1'b0} + 5'(carry);
            if (doubled > 5'd9) begin
               doubled = doubled - 5'd10;
               carry   = 1'b1;
            end else begin
               carry = 1'b0;
            end
            place[j] = doubled[3:0];
         end
      end
      // skip leading zeros, keep at least one digit
      top = DIGIT_PLACES - 1;
      while (top > 0 && place[top] == 4'd0) top--;
      for (int j = top; j >= 0; j--) begin
         entry.digit = place[j];
         entry.last  = (j == 0);
         expected_digits.push_back(entry);
      end
   endtask

   function automatic logic [127:0] ten_power(input int k);
      logic [127:0] p;
      p = 128'd1;
      for (int i = 0; i < k; i++) p = p * 128'd10;
      return p;
   endfunction

   function automatic logic [127:0] random_number();
      return {$urandom, $urandom, $urandom, $urandom};
   endfunction

   task automatic queue_number(input logic [127:0] number, input int unsigned gap,
                               input bit drain);
      pending_type n;
      n.item.value_low  = number[63:0];
      n.item.value_high = number[127:64];
      n.gap             = gap;
      n.drain           = drain;
      pending_numbers.push_back(n);
   endtask

   // driver: present queued numbers, hold start until taken
   always @(posedge clock) begin
      logic next_start;
      if (reset) begin
         start       <= 1'b0;
         idle_cycles <= 0;
      end else begin
         next_start = start;
         if (start && !busy) next_start = 1'b0;
         if (!next_start && pending_numbers.size() != 0) begin
            if (idle_cycles < pending_numbers[0].gap ||
                (pending_numbers[0].drain && (start || expected_digits.size() != 0))) begin
               // the gap runs only while the block is ready
               if (!busy && !start) idle_cycles <= idle_cycles + 1;
            end else begin
               req_item    <= pending_numbers[0].item;
               void'(pending_numbers.pop_front());
               next_start  = 1'b1;
               idle_cycles <= 0;
            end
         end
         start <= next_start;
      end
   end

   // monitor: check each digit, predict on each accepted item
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_strobe !== 1'b0) begin
            if (expected_digits.size() == 0) begin
               report_mismatch("digit strobe with no digit outstanding");
            end else begin
               want = expected_digits.pop_front();
               if (rsp_item.digit !== want.digit)
                  report_mismatch($sformatf("digit %0h, expected %0d",
                                            rsp_item.digit, want.digit));
               if (rsp_item.last !== want.last)
                  report_mismatch($sformatf("last %b, expected %b",
                                            rsp_item.last, want.last));
            end
         end
         if (start && !busy) begin
            push_decimal_digits({req_item.value_high, req_item.value_low});
            accepted_count <= accepted_count + 1;
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      int unsigned  total_items;
      int unsigned  gap;
      int           width;
      int           k;
      int           powers[5];
      logic [127:0] number;
      logic [127:0] mask;

      powers = '{1, 2, 19, 20, 38};

      // directed: zero, single digit, extremes, powers of ten and the numbers just below them
      queue_number(128'd0, 0, 1'b0);
      queue_number(128'd1, 0, 1'b0);
      queue_number(128'd9, 3, 1'b0);
      queue_number(128'd10, 0, 1'b0);
      queue_number({128{1'b1}}, 0, 1'b0);
      queue_number({64'd0, {64{1'b1}}}, 5, 1'b0);
      queue_number({64'd1, 64'd0}, 0, 1'b0);
      queue_number({1'b1, 127'd0}, 0, 1'b1);
      queue_number({65'd0, 1'b1, 62'd0}, 9, 1'b0);
      queue_number({{64{1'b1}}, 64'd0}, 0, 1'b0);
      queue_number({2{64'haaaa_5555_aaaa_5555}}, 0, 1'b0);
      queue_number({2{64'h5555_aaaa_5555_aaaa}}, 1, 1'b0);
      foreach (powers[i]) begin
         k = powers[i];
         queue_number(ten_power(k) - 128'd1, 0, 1'b0);
         queue_number(ten_power(k), $urandom_range(0, 9), 1'b0);
      end

      // random: mix of full-width, narrowed and near powers of ten
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         // odd blocks of 40 run back to back
         gap = ((i / 40) % 2 == 1) ? 0 : $urandom_range(0, 9);
         case ($urandom_range(0, 3))
            0: number = random_number();
            3: begin
               k      = $urandom_range(0, 38);
               number = ten_power(k) + 128'($urandom_range(0, 4)) - 128'd2;
            end
            default: begin
               width  = $urandom_range(1, 128);
               mask   = (width == 128) ? {128{1'b1}} : ((128'd1 << width) - 128'd1);
               number = random_number() & mask;
               number[width-1] = 1'b1;
            end
         endcase
         queue_number(number, gap, (i % 97 == 0));
      end
      total_items = pending_numbers.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count != total_items) @(posedge clock);
      while (expected_digits.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
